// File: rtl/core/x64ild_pkg.sv
// Shared types, constants and opcode classification tables for the x86-64 length decoder.
`default_nettype none

package x64ild_pkg;

    localparam int unsigned COUNT_W = 5;

    localparam logic [7:0] ESCAPE_BYTE   = 8'h0F;
    localparam logic [7:0] OPSIZE_PREFIX = 8'h66;
    localparam logic [7:0] REX_MASK      = 8'hF0;
    localparam logic [7:0] REX_BASE      = 8'h40;
    localparam int unsigned REX_W_BIT    = 3;

    typedef enum logic [1:0] {
        ST_DECODED  = 2'd0,
        ST_UNKNOWN  = 2'd1,
        ST_TOO_LONG = 2'd2
    } decode_status_t;

    typedef enum logic [2:0] {
        IMM_NONE = 3'd0,
        IMM_B    = 3'd1,
        IMM_W    = 3'd2,
        IMM_Z    = 3'd3,
        IMM_V    = 3'd4
    } imm_kind_t;

    typedef struct packed {
        logic      known;
        logic      modrm;
        logic      rel;
        logic      test6;
        logic      test7;
        imm_kind_t imm;
    } op_class_t;

    typedef struct packed {
        logic           valid;
        logic [3:0]     insn_length;
        logic           relative_operand;
        decode_status_t decode_status;
    } ild_result_t;

    function automatic logic is_legacy_prefix(input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        case (b) inside
            8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'h67,
            8'hF0, 8'hF2, 8'hF3: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic op_class_t classify_primary(input logic [7:0] op);
        op_class_t c;
        c = '0;
        c.imm = IMM_NONE;
        if (op < 8'h40) begin
            if (op[2:0] <= 3'd3) begin
                c.known = 1'b1;
                c.modrm = 1'b1;
            end else if (op[2:0] == 3'd4) begin
                c.known = 1'b1;
                c.imm   = IMM_B;
            end else if (op[2:0] == 3'd5) begin
                c.known = 1'b1;
                c.imm   = IMM_Z;
            end
        end else if (op >= 8'h50 && op <= 8'h5F) begin
            c.known = 1'b1;
        end else if (op >= 8'h70 && op <= 8'h7F) begin
            c.known = 1'b1;
            c.rel   = 1'b1;
            c.imm   = IMM_B;
        end else if (op >= 8'h84 && op <= 8'h8B) begin
            c.known = 1'b1;
            c.modrm = 1'b1;
        end else if (op >= 8'h90 && op <= 8'h9F && op != 8'h9A) begin
            c.known = 1'b1;
        end else if (op >= 8'hB0 && op <= 8'hB7) begin
            c.known = 1'b1;
            c.imm   = IMM_B;
        end else if (op >= 8'hB8 && op <= 8'hBF) begin
            c.known = 1'b1;
            c.imm   = IMM_V;
        end else if (op >= 8'hD0 && op <= 8'hD3) begin
            c.known = 1'b1;
            c.modrm = 1'b1;
        end else if (op >= 8'hE0 && op <= 8'hE3) begin
            c.known = 1'b1;
            c.rel   = 1'b1;
            c.imm   = IMM_B;
        end else if (op >= 8'hF8 && op <= 8'hFD) begin
            c.known = 1'b1;
        end else begin
            case (op) inside
                8'h63, 8'h8D, 8'h8F, 8'hFE, 8'hFF:
                begin
                    c.known = 1'b1;
                    c.modrm = 1'b1;
                end
                8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6, 8'h6B:
                begin
                    c.known = 1'b1;
                    c.modrm = 1'b1;
                    c.imm   = IMM_B;
                end
                8'h81, 8'hC7, 8'h69:
                begin
                    c.known = 1'b1;
                    c.modrm = 1'b1;
                    c.imm   = IMM_Z;
                end
                8'hF6:
                begin
                    c.known = 1'b1;
                    c.modrm = 1'b1;
                    c.test6 = 1'b1;
                end
                8'hF7:
                begin
                    c.known = 1'b1;
                    c.modrm = 1'b1;
                    c.test7 = 1'b1;
                end
                8'hA8, 8'h6A, 8'hCD:
                begin
                    c.known = 1'b1;
                    c.imm   = IMM_B;
                end
                8'hA9, 8'h68:
                begin
                    c.known = 1'b1;
                    c.imm   = IMM_Z;
                end
                8'hEB:
                begin
                    c.known = 1'b1;
                    c.rel   = 1'b1;
                    c.imm   = IMM_B;
                end
                8'hE8, 8'hE9:
                begin
                    c.known = 1'b1;
                    c.rel   = 1'b1;
                    c.imm   = IMM_Z;
                end
                8'hC2, 8'hCA:
                begin
                    c.known = 1'b1;
                    c.imm   = IMM_W;
                end
                8'hC3, 8'hC9, 8'hCB, 8'hCC, 8'hCE, 8'hCF, 8'hF4, 8'hF5:
                begin
                    c.known = 1'b1;
                end
                default:
                begin
                    c.known = 1'b0;
                end
            endcase
        end
        return c;
    endfunction

    function automatic op_class_t classify_escape(input logic [7:0] op);
        op_class_t c;
        c = '0;
        c.imm = IMM_NONE;
        if (op[7:4] == 4'h8) begin
            c.known = 1'b1;
            c.rel   = 1'b1;
            c.imm   = IMM_Z;
        end else begin
            case (op) inside
                8'h05, 8'h31, 8'h34, 8'h35:
                begin
                    c.known = 1'b1;
                end
                8'h1F, 8'hAF, 8'hB6, 8'hB7, 8'hBE, 8'hBF:
                begin
                    c.known = 1'b1;
                    c.modrm = 1'b1;
                end
                default:
                begin
                    c.known = 1'b0;
                end
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/x64ild_if.sv
// Valid/ready stream interfaces for code bytes and decode results.
`default_nettype none

interface x64ild_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

interface x64ild_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] insn_length;
    logic       relative_operand;
    logic [1:0] decode_status;

    modport source (output valid, output insn_length, output relative_operand,
                    output decode_status, input ready);
    modport sink (input valid, input insn_length, input relative_operand,
                  input decode_status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/x64_instruction_length_decoder.sv
// Top level of the byte-serial x86-64 instruction length decoder.
// Takes one code byte per clock on byte_in and reports each instruction boundary on
// result_out: length, a flag for rel8/rel32 branches or RIP-relative addressing, and a
// status (decoded, unknown opcode, or longer than MAX_INSN_BYTES). A byte is registered
// on entry, decoded combinationally against the per-instruction state, and its result (if
// any) is then registered in the output register when the input stage advances. A result
// thus passes the input byte register and then the output register on its way to
// result_out. Throughput is one byte per clock, limited by the single decode state update
// per byte; a stalled result_out holds the input stage.
`default_nettype none

module x64_instruction_length_decoder #(
    parameter int unsigned MAX_INSN_BYTES = 15
) (
    input  wire               clk,
    input  wire               rst_n,
    x64ild_byte_if.sink       byte_in,
    x64ild_result_if.source   result_out
);

    logic                    in_valid_reg;
    logic [7:0]              byte_reg;
    logic                    out_valid_reg;
    logic [3:0]              insn_length_reg;
    logic                    relative_reg;
    logic [1:0]              status_reg;
    logic                    advance;
    x64ild_pkg::ild_result_t dec_result;

    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign byte_in.ready = !in_valid_reg || advance;

    x64ild_decoder #(
        .MAX_INSN_BYTES (MAX_INSN_BYTES)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (advance),
        .code_byte (byte_reg),
        .result    (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (byte_in.ready) begin
                in_valid_reg <= byte_in.valid;
            end
            if (advance) begin
                out_valid_reg <= dec_result.valid;
            end else if (result_out.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid) begin
            byte_reg <= byte_in.code_byte;
        end
        if (advance && dec_result.valid) begin
            insn_length_reg <= dec_result.insn_length;
            relative_reg    <= dec_result.relative_operand;
            status_reg      <= dec_result.decode_status;
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.insn_length      = insn_length_reg;
    assign result_out.relative_operand = relative_reg;
    assign result_out.decode_status    = status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> byte_in.ready)
        else $error("input stalled with empty output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != x64ild_pkg::ST_DECODED
        |-> insn_length_reg == 4'd0 && !relative_reg)
        else $error("failed decode carries length or relative flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == x64ild_pkg::ST_DECODED |-> insn_length_reg != 4'd0)
        else $error("decoded instruction with zero length");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> status_reg != 2'd3)
        else $error("undefined decode status");

endmodule

`default_nettype wire

// File: rtl/core/x64ild_decoder.sv
// Per-byte decode state machine: prefixes, opcode, ModRM, SIB, displacement, immediate.
`default_nettype none

module x64ild_decoder #(
    parameter int unsigned MAX_INSN_BYTES = 15
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      take,
    input  wire  [7:0]               code_byte,
    output x64ild_pkg::ild_result_t  result
);

    typedef enum logic [2:0] {
        PH_PREFIX   = 3'd0,
        PH_OPCODE   = 3'd1,
        PH_ESCAPE   = 3'd2,
        PH_MODRM    = 3'd3,
        PH_SIB      = 3'd4,
        PH_DISP     = 3'd5,
        PH_IMM      = 3'd6,
        PH_SIB_MOD0 = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        TK_NONE = 2'd0,
        TK_F6   = 2'd1,
        TK_F7   = 2'd2
    } test_kind_t;

    phase_t     phase_reg, phase_next;
    logic       opsize_reg, opsize_next;
    logic       rexw_reg, rexw_next;
    logic [3:0] bytes_so_far_reg, bytes_so_far_next;
    logic [3:0] imm_pending_reg, imm_pending_next;
    logic [2:0] disp_pending_reg, disp_pending_next;
    logic       relative_reg, relative_next;
    test_kind_t test_kind_reg, test_kind_next;

    logic [x64ild_pkg::COUNT_W-1:0] count;
    logic [3:0]                     zsize;
    x64ild_pkg::op_class_t          cls;
    logic                           take_op;
    logic                           apply;
    logic                           chk_disp;
    logic                           done;
    logic                           unknown;
    logic                           clear;
    logic [1:0]                     mod_f;
    logic [2:0]                     rm_f;
    logic [2:0]                     reg_f;

    assign count = {1'b0, bytes_so_far_reg} + x64ild_pkg::COUNT_W'(1);
    assign zsize = opsize_reg ? 4'd2 : 4'd4;
    assign mod_f = code_byte[7:6];
    assign rm_f  = code_byte[2:0];
    assign reg_f = code_byte[5:3];

    always_comb
    begin
        phase_next        = phase_reg;
        opsize_next       = opsize_reg;
        rexw_next         = rexw_reg;
        bytes_so_far_next = bytes_so_far_reg;
        imm_pending_next  = imm_pending_reg;
        disp_pending_next = disp_pending_reg;
        relative_next     = relative_reg;
        test_kind_next    = test_kind_reg;
        cls               = '0;
        take_op           = 1'b0;
        apply             = 1'b0;
        chk_disp          = 1'b0;
        done              = 1'b0;
        unknown           = 1'b0;
        clear             = 1'b0;
        result            = '0;
        result.decode_status = x64ild_pkg::ST_DECODED;

        unique case (phase_reg)
            PH_PREFIX:
            begin
                if (x64ild_pkg::is_legacy_prefix(code_byte)) begin
                    opsize_next = opsize_reg;
                end else if (code_byte == x64ild_pkg::OPSIZE_PREFIX) begin
                    opsize_next = 1'b1;
                end else if ((code_byte & x64ild_pkg::REX_MASK) == x64ild_pkg::REX_BASE)
                begin
                    rexw_next  = code_byte[x64ild_pkg::REX_W_BIT];
                    phase_next = PH_OPCODE;
                end else begin
                    take_op = 1'b1;
                end
            end
            PH_OPCODE:
            begin
                take_op = 1'b1;
            end
            PH_ESCAPE:
            begin
                cls   = x64ild_pkg::classify_escape(code_byte);
                apply = 1'b1;
            end
            PH_MODRM:
            begin
                chk_disp = 1'b1;
                if (test_kind_reg != TK_NONE && reg_f <= 3'd1) begin
                    imm_pending_next = (test_kind_reg == TK_F6) ? 4'd1 : zsize;
                end
                if (mod_f != 2'd3) begin
                    if (mod_f == 2'd0 && rm_f == 3'd5) begin
                        relative_next     = 1'b1;
                        disp_pending_next = 3'd4;
                    end else if (rm_f == 3'd4) begin
                        chk_disp = 1'b0;
                        if (mod_f == 2'd0) begin
                            phase_next = PH_SIB_MOD0;
                        end else begin
                            disp_pending_next = (mod_f == 2'd1) ? 3'd1 : 3'd4;
                            phase_next        = PH_SIB;
                        end
                    end else if (mod_f == 2'd1) begin
                        disp_pending_next = 3'd1;
                    end else if (mod_f == 2'd2) begin
                        disp_pending_next = 3'd4;
                    end
                end
            end
            PH_SIB:
            begin
                chk_disp = 1'b1;
            end
            PH_SIB_MOD0:
            begin
                if (rm_f == 3'd5) begin
                    disp_pending_next = 3'd4;
                end
                chk_disp = 1'b1;
            end
            PH_DISP:
            begin
                disp_pending_next = disp_pending_reg - 3'd1;
                chk_disp          = 1'b1;
            end
            PH_IMM:
            begin
                imm_pending_next = imm_pending_reg - 4'd1;
                done             = (imm_pending_next == 4'd0);
            end
            default:
            begin
                phase_next = PH_PREFIX;
            end
        endcase

        if (take_op) begin
            if (code_byte == x64ild_pkg::ESCAPE_BYTE) begin
                phase_next = PH_ESCAPE;
            end else begin
                cls   = x64ild_pkg::classify_primary(code_byte);
                apply = 1'b1;
            end
        end

        if (apply) begin
            if (!cls.known) begin
                unknown = 1'b1;
            end else begin
                if (cls.rel) begin
                    relative_next = 1'b1;
                end
                case (cls.imm)
                    x64ild_pkg::IMM_B: imm_pending_next = 4'd1;
                    x64ild_pkg::IMM_W: imm_pending_next = 4'd2;
                    x64ild_pkg::IMM_Z: imm_pending_next = zsize;
                    x64ild_pkg::IMM_V: imm_pending_next = rexw_reg ? 4'd8 : zsize;
                    default:           imm_pending_next = imm_pending_reg;
                endcase
                if (cls.test6) begin
                    test_kind_next = TK_F6;
                end
                if (cls.test7) begin
                    test_kind_next = TK_F7;
                end
                if (cls.modrm) begin
                    phase_next = PH_MODRM;
                end else begin
                    chk_disp = 1'b1;
                end
            end
        end

        if (chk_disp) begin
            if (disp_pending_next != 3'd0) begin
                phase_next = PH_DISP;
            end else if (imm_pending_next != 4'd0) begin
                phase_next = PH_IMM;
            end else begin
                done = 1'b1;
            end
        end

        if (unknown) begin
            result.valid         = take;
            result.decode_status = x64ild_pkg::ST_UNKNOWN;
            clear                = 1'b1;
        end else if (done) begin
            result.valid            = take;
            result.insn_length      = (count > x64ild_pkg::COUNT_W'(15)) ? 4'd15 : count[3:0];
            result.relative_operand = relative_next;
            clear                   = 1'b1;
        end else if (count >= x64ild_pkg::COUNT_W'(MAX_INSN_BYTES)) begin
            result.valid         = take;
            result.decode_status = x64ild_pkg::ST_TOO_LONG;
            clear                = 1'b1;
        end else begin
            bytes_so_far_next = count[3:0];
        end

        if (clear) begin
            phase_next        = PH_PREFIX;
            opsize_next       = 1'b0;
            rexw_next         = 1'b0;
            bytes_so_far_next = 4'd0;
            imm_pending_next  = 4'd0;
            disp_pending_next = 3'd0;
            relative_next     = 1'b0;
            test_kind_next    = TK_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_PREFIX;
            opsize_reg       <= 1'b0;
            rexw_reg         <= 1'b0;
            bytes_so_far_reg <= 4'd0;
            imm_pending_reg  <= 4'd0;
            disp_pending_reg <= 3'd0;
            relative_reg     <= 1'b0;
            test_kind_reg    <= TK_NONE;
        end else if (take) begin
            phase_reg        <= phase_next;
            opsize_reg       <= opsize_next;
            rexw_reg         <= rexw_next;
            bytes_so_far_reg <= bytes_so_far_next;
            imm_pending_reg  <= imm_pending_next;
            disp_pending_reg <= disp_pending_next;
            relative_reg     <= relative_next;
            test_kind_reg    <= test_kind_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |=> bytes_so_far_reg == 4'd0 && phase_reg == PH_PREFIX)
        else $error("decoder state not cleared after result");

    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, bytes_so_far_reg} < x64ild_pkg::COUNT_W'(MAX_INSN_BYTES))
        else $error("byte count reached length bound");

endmodule

`default_nettype wire
